@@ hdl/sf2d_pkg.sv @@
// Shared types and constants for the 2D spring force pipeline.
// No dependencies; imported by every module of the block.
package sf2d_pkg;

    localparam int DATA_W    = 32;
    localparam int LEN_W     = 33;
    localparam int RAD_W     = 66;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_SPRING_CONSTANT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REST_LENGTH     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BUNGEE_MODE     = 2'd2;

    localparam logic [DATA_W-1:0] LIM_POS = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] LIM_NEG = 32'h8000_0000;

    typedef struct packed {
        logic             fm;
        logic             nx;
        logic             ny;
        logic [LEN_W-1:0] adx;
        logic [LEN_W-1:0] ady;
    } t_sq_tag;

    typedef struct packed {
        logic sat;
        logic neg;
        logic skip;
        logic zero;
    } t_div_tag;

    typedef struct packed {
        logic [DATA_W-1:0] force_x;
        logic [DATA_W-1:0] force_y;
        logic              applied;
    } t_result;

endpackage

@@ hdl/sf2d_isqrt.sv @@
// Pipelined floor square root, one result bit per stage.
// Depends on sf2d_pkg; carries a tag and a valid bit beside the data.
module sf2d_isqrt #(
    parameter int TAG_W = 1
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_vld,
    input  logic [sf2d_pkg::RAD_W-1:0] i_rad,
    input  logic [TAG_W-1:0]           i_tag,
    output logic                       o_vld,
    output logic [sf2d_pkg::LEN_W-1:0] o_root,
    output logic [TAG_W-1:0]           o_tag
);
    import sf2d_pkg::*;

    localparam int STEPS = LEN_W;
    localparam int REM_W = LEN_W + 4;

    logic             r_vld  [STEPS];
    logic [RAD_W-1:0] r_rad  [STEPS];
    logic [REM_W-1:0] r_rem  [STEPS];
    logic [LEN_W-1:0] r_root [STEPS];
    logic [TAG_W-1:0] r_tag  [STEPS];

    for (genvar i = 0; i < STEPS; i++) begin : g_step
        logic             vld_in;
        logic [RAD_W-1:0] rad_in;
        logic [REM_W-1:0] rem_in;
        logic [LEN_W-1:0] root_in;
        logic [TAG_W-1:0] tag_in;
        logic [REM_W-1:0] rem_sh;
        logic [REM_W-1:0] trial;
        logic             fit;

        if (i == 0) begin : g_first
            assign vld_in  = i_vld;
            assign rad_in  = i_rad;
            assign rem_in  = '0;
            assign root_in = '0;
            assign tag_in  = i_tag;
        end else begin : g_next
            assign vld_in  = r_vld[i-1];
            assign rad_in  = r_rad[i-1];
            assign rem_in  = r_rem[i-1];
            assign root_in = r_root[i-1];
            assign tag_in  = r_tag[i-1];
        end

        assign rem_sh = {rem_in[REM_W-3:0], rad_in[RAD_W-1:RAD_W-2]};
        assign trial  = {2'b00, root_in, 2'b01};
        assign fit    = rem_sh >= trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[i] <= 1'b0;
            end else if (i_en) begin
                r_vld[i] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad[i]  <= {rad_in[RAD_W-3:0], 2'b00};
                r_rem[i]  <= fit ? (rem_sh - trial) : rem_sh;
                r_root[i] <= {root_in[LEN_W-2:0], fit};
                r_tag[i]  <= tag_in;
            end
        end
    end

    assign o_vld  = r_vld[STEPS-1];
    assign o_root = r_root[STEPS-1];
    assign o_tag  = r_tag[STEPS-1];

endmodule

@@ hdl/sf2d_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, 32 stages.
// Depends on sf2d_pkg; the start remainder must be below the divisor.
module sf2d_div #(
    parameter int TAG_W = 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_vld,
    input  logic [sf2d_pkg::LEN_W-1:0]  i_den,
    input  logic [sf2d_pkg::LEN_W-1:0]  i_rem,
    input  logic [sf2d_pkg::DATA_W-1:0] i_num,
    input  logic [TAG_W-1:0]            i_tag,
    output logic                        o_vld,
    output logic [sf2d_pkg::DATA_W-1:0] o_quo,
    output logic [TAG_W-1:0]            o_tag
);
    import sf2d_pkg::*;

    localparam int STEPS = DATA_W;

    logic              r_vld [STEPS];
    logic [LEN_W-1:0]  r_den [STEPS];
    logic [LEN_W-1:0]  r_rem [STEPS];
    logic [DATA_W-1:0] r_num [STEPS];
    logic [DATA_W-1:0] r_quo [STEPS];
    logic [TAG_W-1:0]  r_tag [STEPS];

    for (genvar i = 0; i < STEPS; i++) begin : g_step
        logic              vld_in;
        logic [LEN_W-1:0]  den_in;
        logic [LEN_W-1:0]  rem_in;
        logic [DATA_W-1:0] num_in;
        logic [DATA_W-1:0] quo_in;
        logic [TAG_W-1:0]  tag_in;
        logic [LEN_W:0]    rem_sh;
        logic [LEN_W:0]    diff;
        logic              fit;

        if (i == 0) begin : g_first
            assign vld_in = i_vld;
            assign den_in = i_den;
            assign rem_in = i_rem;
            assign num_in = i_num;
            assign quo_in = '0;
            assign tag_in = i_tag;
        end else begin : g_next
            assign vld_in = r_vld[i-1];
            assign den_in = r_den[i-1];
            assign rem_in = r_rem[i-1];
            assign num_in = r_num[i-1];
            assign quo_in = r_quo[i-1];
            assign tag_in = r_tag[i-1];
        end

        assign rem_sh = {rem_in, num_in[DATA_W-1]};
        assign diff   = rem_sh - {1'b0, den_in};
        assign fit    = rem_sh >= {1'b0, den_in};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[i] <= 1'b0;
            end else if (i_en) begin
                r_vld[i] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den[i] <= den_in;
                r_rem[i] <= fit ? diff[LEN_W-1:0] : rem_sh[LEN_W-1:0];
                r_num[i] <= {num_in[DATA_W-2:0], 1'b0};
                r_quo[i] <= {quo_in[DATA_W-2:0], fit};
                r_tag[i] <= tag_in;
            end
        end
    end

    assign o_vld = r_vld[STEPS-1];
    assign o_quo = r_quo[STEPS-1];
    assign o_tag = r_tag[STEPS-1];

endmodule

@@ hdl/spring_force_2d.sv @@
// Top level of the 2D spring force pipeline.
// Depends on sf2d_pkg, sf2d_isqrt and sf2d_div.
//
// Computes k * (|d| - rest) along d / |d| with d = other - self, in fixed point
// with FRAC_BITS fraction bits, saturating each force component to 32 bits.
// One item is taken per clock while o_in_ready is high; each result passes through
// the difference, magnitude, square and sum stages, the bit-per-stage square
// root, the stretch, spring magnitude and wide product stages, the bit-per-stage
// divide by length, and the two-entry output buffer.
// The pipeline stalls only while both output buffer entries are held.
// Infinite mass and a compressed bungee give zero force with force_applied
// low; a zero length gives zero force with force_applied high.
module spring_force_2d #(
    parameter int FRAC_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [sf2d_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [sf2d_pkg::DATA_W-1:0]     i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic signed [sf2d_pkg::DATA_W-1:0] i_self_x,
    input  logic signed [sf2d_pkg::DATA_W-1:0] i_self_y,
    input  logic signed [sf2d_pkg::DATA_W-1:0] i_other_x,
    input  logic signed [sf2d_pkg::DATA_W-1:0] i_other_y,
    input  logic                            i_finite_mass,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic signed [sf2d_pkg::DATA_W-1:0] o_force_x,
    output logic signed [sf2d_pkg::DATA_W-1:0] o_force_y,
    output logic                            o_force_applied
);
    import sf2d_pkg::*;

    localparam int PROD_W = DATA_W + LEN_W;
    localparam int MAG_W  = PROD_W - FRAC_BITS;
    localparam int MH_W   = MAG_W - DATA_W;
    localparam int NUM_W  = MAG_W + DATA_W;
    localparam int SQ_W   = 2 * DATA_W + 1;

    // configuration
    logic [DATA_W-1:0] r_spring_constant;
    logic [DATA_W-2:0] r_rest_length;
    logic              r_bungee_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spring_constant <= 32'd65536;
            r_rest_length     <= 31'd65536;
            r_bungee_mode     <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SPRING_CONSTANT: r_spring_constant <= i_cfg_data;
                CFG_REST_LENGTH:     r_rest_length     <= i_cfg_data[DATA_W-2:0];
                CFG_BUNGEE_MODE:     r_bungee_mode     <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    logic w_en;
    logic w_push;
    logic w_pop;
    logic [1:0] r_cnt;

    assign w_en       = (r_cnt != 2'd2);
    assign o_in_ready = w_en;

    // stage 1: differences
    logic                    r1_vld;
    logic signed [LEN_W-1:0] r1_dx, r1_dy;
    logic                    r1_fm;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (w_en) begin
            r1_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_dx <= {i_other_x[DATA_W-1], i_other_x} - {i_self_x[DATA_W-1], i_self_x};
            r1_dy <= {i_other_y[DATA_W-1], i_other_y} - {i_self_y[DATA_W-1], i_self_y};
            r1_fm <= i_finite_mass;
        end
    end

    // stage 2: magnitudes
    logic             r2_vld;
    logic [LEN_W-1:0] r2_adx, r2_ady;
    logic             r2_nx, r2_ny, r2_fm;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (w_en) begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_adx <= r1_dx[LEN_W-1] ? LEN_W'(-r1_dx) : LEN_W'(r1_dx);
            r2_ady <= r1_dy[LEN_W-1] ? LEN_W'(-r1_dy) : LEN_W'(r1_dy);
            r2_nx  <= r1_dx[LEN_W-1];
            r2_ny  <= r1_dy[LEN_W-1];
            r2_fm  <= r1_fm;
        end
    end

    // stage 3: squares; a top bit set means the low word is zero
    logic                r3_vld;
    logic [SQ_W-1:0]     r3_sqx, r3_sqy;
    t_sq_tag             r3_tag;
    logic [2*DATA_W-1:0] n3_sqx, n3_sqy;

    assign n3_sqx = r2_adx[DATA_W-1:0] * r2_adx[DATA_W-1:0];
    assign n3_sqy = r2_ady[DATA_W-1:0] * r2_ady[DATA_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (w_en) begin
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_sqx <= {r2_adx[LEN_W-1], n3_sqx};
            r3_sqy <= {r2_ady[LEN_W-1], n3_sqy};
            r3_tag <= '{fm: r2_fm, nx: r2_nx, ny: r2_ny, adx: r2_adx, ady: r2_ady};
        end
    end

    // stage 4: sum of squares
    logic             r4_vld;
    logic [RAD_W-1:0] r4_rad;
    t_sq_tag          r4_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else if (w_en) begin
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_rad <= {1'b0, r3_sqx} + {1'b0, r3_sqy};
            r4_tag <= r3_tag;
        end
    end

    logic             w_sq_vld;
    logic [LEN_W-1:0] w_len;
    t_sq_tag          w_sq_tag;

    sf2d_isqrt #(
        .TAG_W ($bits(t_sq_tag))
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r4_vld),
        .i_rad   (r4_rad),
        .i_tag   (r4_tag),
        .o_vld   (w_sq_vld),
        .o_root  (w_len),
        .o_tag   (w_sq_tag)
    );

    // stage 5: stretch
    logic                  r5_vld;
    logic signed [LEN_W:0] r5_delta;
    logic [LEN_W-1:0]      r5_len;
    t_sq_tag               r5_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else if (w_en) begin
            r5_vld <= w_sq_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r5_delta <= {1'b0, w_len} - {3'b000, r_rest_length};
            r5_len   <= w_len;
            r5_tag   <= w_sq_tag;
        end
    end

    // stage 6: stretch magnitude and skip flags
    logic             r6_vld;
    logic [LEN_W-1:0] r6_adelta;
    logic             r6_dneg, r6_skip, r6_zero;
    logic [LEN_W-1:0] r6_len;
    t_sq_tag          r6_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_vld <= 1'b0;
        end else if (w_en) begin
            r6_vld <= r5_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r6_adelta <= r5_delta[LEN_W] ? LEN_W'(-r5_delta) : LEN_W'(r5_delta);
            r6_dneg   <= r5_delta[LEN_W];
            r6_skip   <= !r5_tag.fm || (r_bungee_mode && r5_delta[LEN_W]);
            r6_zero   <= (r5_len == '0);
            r6_len    <= r5_len;
            r6_tag    <= r5_tag;
        end
    end

    // stage 7: stiffness times stretch, low word
    logic              r7_vld;
    logic [2*DATA_W-1:0] r7_pk;
    logic              r7_dtop;
    logic              r7_dneg, r7_skip, r7_zero;
    logic [LEN_W-1:0]  r7_len;
    t_sq_tag           r7_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_vld <= 1'b0;
        end else if (w_en) begin
            r7_vld <= r6_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r7_pk   <= r_spring_constant * r6_adelta[DATA_W-1:0];
            r7_dtop <= r6_adelta[LEN_W-1];
            r7_dneg <= r6_dneg;
            r7_skip <= r6_skip;
            r7_zero <= r6_zero;
            r7_len  <= r6_len;
            r7_tag  <= r6_tag;
        end
    end

    // stage 8: spring magnitude
    logic              r8_vld;
    logic [MAG_W-1:0]  r8_mag;
    logic              r8_negx, r8_negy, r8_skip, r8_zero;
    logic [LEN_W-1:0]  r8_len;
    t_sq_tag           r8_tag;
    logic [PROD_W-1:0] n8_prod;

    assign n8_prod = {1'b0, r7_pk}
                   + (r7_dtop ? {1'b0, r_spring_constant, {DATA_W{1'b0}}} : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r8_vld <= 1'b0;
        end else if (w_en) begin
            r8_vld <= r7_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r8_mag  <= n8_prod[PROD_W-1:FRAC_BITS];
            r8_negx <= r7_dneg ^ r7_tag.nx;
            r8_negy <= r7_dneg ^ r7_tag.ny;
            r8_skip <= r7_skip;
            r8_zero <= r7_zero;
            r8_len  <= r7_len;
            r8_tag  <= r7_tag;
        end
    end

    // stage 9: partial products of magnitude and component
    logic                r9_vld;
    logic [2*DATA_W-1:0] r9_pllx, r9_plly;
    logic [MAG_W-1:0]    r9_phlx, r9_phly;
    logic [MAG_W-1:0]    r9_mag;
    logic                r9_topx, r9_topy;
    t_div_tag            r9_dtx, r9_dty;
    logic [LEN_W-1:0]    r9_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r9_vld <= 1'b0;
        end else if (w_en) begin
            r9_vld <= r8_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r9_pllx <= r8_mag[DATA_W-1:0] * r8_tag.adx[DATA_W-1:0];
            r9_plly <= r8_mag[DATA_W-1:0] * r8_tag.ady[DATA_W-1:0];
            r9_phlx <= r8_mag[MAG_W-1:DATA_W] * r8_tag.adx[DATA_W-1:0];
            r9_phly <= r8_mag[MAG_W-1:DATA_W] * r8_tag.ady[DATA_W-1:0];
            r9_mag  <= r8_mag;
            r9_topx <= r8_tag.adx[LEN_W-1];
            r9_topy <= r8_tag.ady[LEN_W-1];
            r9_dtx  <= '{sat: 1'b0, neg: r8_negx, skip: r8_skip, zero: r8_zero};
            r9_dty  <= '{sat: 1'b0, neg: r8_negy, skip: r8_skip, zero: r8_zero};
            r9_len  <= r8_len;
        end
    end

    // stage 10: full numerators
    logic             r10_vld;
    logic [NUM_W-1:0] r10_nx, r10_ny;
    t_div_tag         r10_dtx, r10_dty;
    logic [LEN_W-1:0] r10_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r10_vld <= 1'b0;
        end else if (w_en) begin
            r10_vld <= r9_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r10_nx  <= r9_topx ? {r9_mag, {DATA_W{1'b0}}}
                               : NUM_W'(r9_pllx) + {r9_phlx, {DATA_W{1'b0}}};
            r10_ny  <= r9_topy ? {r9_mag, {DATA_W{1'b0}}}
                               : NUM_W'(r9_plly) + {r9_phly, {DATA_W{1'b0}}};
            r10_dtx <= r9_dtx;
            r10_dty <= r9_dty;
            r10_len <= r9_len;
        end
    end

    // stage 11: flag quotients past 32 bits, seed the divide
    logic              r11_vld;
    logic [LEN_W-1:0]  r11_remx, r11_remy;
    logic [DATA_W-1:0] r11_numx, r11_numy;
    t_div_tag          r11_dtx, r11_dty;
    logic [LEN_W-1:0]  r11_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r11_vld <= 1'b0;
        end else if (w_en) begin
            r11_vld <= r10_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r11_remx <= r10_nx[DATA_W+LEN_W-1:DATA_W];
            r11_remy <= r10_ny[DATA_W+LEN_W-1:DATA_W];
            r11_numx <= r10_nx[DATA_W-1:0];
            r11_numy <= r10_ny[DATA_W-1:0];
            r11_dtx  <= '{sat:  r10_nx[NUM_W-1:DATA_W] >= MAG_W'(r10_len),
                          neg:  r10_dtx.neg, skip: r10_dtx.skip, zero: r10_dtx.zero};
            r11_dty  <= '{sat:  r10_ny[NUM_W-1:DATA_W] >= MAG_W'(r10_len),
                          neg:  r10_dty.neg, skip: r10_dty.skip, zero: r10_dty.zero};
            r11_len  <= r10_len;
        end
    end

    logic              w_qx_vld, w_qy_vld;
    logic [DATA_W-1:0] w_qx, w_qy;
    t_div_tag          w_tx, w_ty;

    sf2d_div #(
        .TAG_W ($bits(t_div_tag))
    ) u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r11_vld),
        .i_den   (r11_len),
        .i_rem   (r11_remx),
        .i_num   (r11_numx),
        .i_tag   (r11_dtx),
        .o_vld   (w_qx_vld),
        .o_quo   (w_qx),
        .o_tag   (w_tx)
    );

    sf2d_div #(
        .TAG_W ($bits(t_div_tag))
    ) u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r11_vld),
        .i_den   (r11_len),
        .i_rem   (r11_remy),
        .i_num   (r11_numy),
        .i_tag   (r11_dty),
        .o_vld   (w_qy_vld),
        .o_quo   (w_qy),
        .o_tag   (w_ty)
    );

    // saturate, sign and apply the special cases
    logic [DATA_W-1:0] w_limx, w_limy, w_satx, w_saty;
    t_result           w_res;

    assign w_limx = w_tx.neg ? LIM_NEG : LIM_POS;
    assign w_limy = w_ty.neg ? LIM_NEG : LIM_POS;
    assign w_satx = (w_tx.sat || (w_qx > w_limx)) ? w_limx : w_qx;
    assign w_saty = (w_ty.sat || (w_qy > w_limy)) ? w_limy : w_qy;

    always_comb begin
        w_res.force_x = w_tx.neg ? (~w_satx + 1'b1) : w_satx;
        w_res.force_y = w_ty.neg ? (~w_saty + 1'b1) : w_saty;
        w_res.applied = 1'b1;
        if (w_tx.skip) begin
            w_res = '0;
        end else if (w_tx.zero) begin
            w_res.force_x = '0;
            w_res.force_y = '0;
        end
    end

    // two-entry output buffer
    t_result r_e0, r_e1;

    assign w_push = w_en && w_qx_vld;
    assign w_pop  = o_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push && w_pop) begin
            r_e0 <= (r_cnt == 2'd1) ? w_res : r_e1;
            r_e1 <= w_res;
        end else if (w_push) begin
            if (r_cnt == 2'd0) begin
                r_e0 <= w_res;
            end else begin
                r_e1 <= w_res;
            end
        end else if (w_pop) begin
            r_e0 <= r_e1;
        end
    end

    assign o_out_valid     = (r_cnt != 2'd0);
    assign o_force_x       = r_e0.force_x;
    assign o_force_y       = r_e0.force_y;
    assign o_force_applied = r_e0.applied;

    a_lanes_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_qx_vld == w_qy_vld)
        else $error("x and y divider lanes out of step");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("output buffer count overflow");

    a_skip_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_force_applied) |-> (o_force_x == '0 && o_force_y == '0))
        else $error("skipped item carries a force");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && !w_push && r_cnt == 2'd1) |=> !o_out_valid)
        else $error("output still valid after last transfer");

endmodule
